// ===== rtl/core/pse_pkg.sv =====
package pse_pkg;

    // Stream field widths
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 48;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SUB   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_MUL   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DIV   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DIVZERO   = 2'd3;

    // Divider iteration count
    localparam int DIV_STEPS = VALUE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // What one stack cell does on a clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_UP,
        CELL_LOAD_DOWN
    } cell_cmd_t;

    // Effect of one token on the stack
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_REPLACE,
        ACT_CLEAR
    } stack_act_t;

    // Token sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_WAIT,
        S_WRITE
    } seq_state_t;

    // Divider sequencer
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIX
    } div_state_t;

endpackage

// ===== rtl/core/postfix_stack_evaluator.sv =====
// Each token is latched at the input beat, decoded in EXEC and committed in WRITE
// once the output slot is free; a divide first waits in DIV_WAIT for the divider.
// One token at a time: a new beat is accepted only after the previous one commits.
// Divides use a one-bit-per-cycle restoring divider.
// Reset (aresetn low, synchronous) empties the stack and drops any pending beat.
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] literal_value
    input  logic [S_USER_W-1:0] s_tuser,   // [2:0] opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [31:0] top_value, [38:32] stack_depth,
                                           // [40:39] status, [47:41] zero
);

    localparam int DW = $clog2(STACK_DEPTH + 1);

    seq_state_t         state_reg, state_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [VALUE_W-1:0]  lit_reg;
    logic [VALUE_W-1:0]  res_reg, res_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    stack_act_t          act_reg, act_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                div_start;
    logic                div_done;
    logic [VALUE_W-1:0]  div_quot;
    logic                apply;
    logic [VALUE_W-1:0]  top_next;
    logic [DW+DEPTH_W-1:0] depth_ext;

    logic [VALUE_W-1:0]  cell_q   [STACK_DEPTH];
    cell_cmd_t           cell_cmd [STACK_DEPTH];
    logic [VALUE_W-1:0]  top_in;

    logic                s_beat;
    logic                out_free;

    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Sequencer: decode in EXEC, wait on divider, commit when the output slot frees
    always_comb begin
        state_next  = state_reg;
        res_next    = res_reg;
        status_next = status_reg;
        act_next    = act_reg;
        div_start   = 1'b0;
        apply       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = STAT_OK;
                act_next    = ACT_NONE;
                res_next    = res_reg;
                state_next  = S_WRITE;
                case (op_reg)
                    OP_PUSH: begin
                        if (depth_reg == DW'(STACK_DEPTH)) begin
                            status_next = STAT_FULL;
                        end else begin
                            act_next = ACT_PUSH;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (depth_reg < DW'(2)) begin
                            status_next = STAT_UNDERFLOW;
                        end else if (op_reg == OP_DIV && cell_q[0] == '0) begin
                            status_next = STAT_DIVZERO;
                        end else begin
                            act_next = ACT_REPLACE;
                            case (op_reg)
                                OP_ADD:  res_next = cell_q[1] + cell_q[0];
                                OP_SUB:  res_next = cell_q[1] - cell_q[0];
                                OP_MUL:  res_next = cell_q[1] * cell_q[0];
                                default: res_next = res_reg;
                            endcase
                            if (op_reg == OP_DIV) begin
                                div_start  = 1'b1;
                                state_next = S_DIV_WAIT;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        act_next = ACT_CLEAR;
                    end
                    default: begin
                        act_next = ACT_NONE;
                    end
                endcase
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    res_next   = div_quot;
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    apply      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Depth and top of stack after the token
    always_comb begin
        case (act_reg)
            ACT_PUSH: begin
                depth_next = depth_reg + 1'b1;
                top_next   = lit_reg;
            end
            ACT_REPLACE: begin
                depth_next = depth_reg - 1'b1;
                top_next   = res_reg;
            end
            ACT_CLEAR: begin
                depth_next = '0;
                top_next   = '0;
            end
            default: begin
                depth_next = depth_reg;
                top_next   = (depth_reg != '0) ? cell_q[0] : '0;
            end
        endcase
    end

    assign depth_ext = {{DEPTH_W{1'b0}}, depth_next};

    // Output register: load on commit, drop after the beat is taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (apply) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'b0, status_reg, depth_ext[DEPTH_W-1:0], top_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            act_reg      <= ACT_NONE;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            act_reg      <= act_next;
            if (apply) begin
                depth_reg <= depth_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            op_reg  <= s_tuser;
            lit_reg <= s_tdata;
        end
        res_reg     <= res_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Cell commands: shift down on push, shift up under the new top on replace
    assign top_in = (act_reg == ACT_PUSH) ? lit_reg : res_reg;

    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            cell_cmd[i] = CELL_HOLD;
            if (apply && act_reg == ACT_PUSH) begin
                cell_cmd[i] = CELL_LOAD_UP;
            end else if (apply && act_reg == ACT_REPLACE) begin
                cell_cmd[i] = (i == 0) ? CELL_LOAD_UP : CELL_LOAD_DOWN;
            end
        end
    end

    // Stack as a row of cells, top entry in cell 0
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] up_w;
        logic [VALUE_W-1:0] down_w;
        if (g == 0) begin : g_first
            assign up_w = top_in;
        end else begin : g_mid_up
            assign up_w = cell_q[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign down_w = '0;
        end else begin : g_mid_down
            assign down_w = cell_q[g+1];
        end
        pse_cell u_cell (
            .aclk      (aclk),
            .cmd       (cell_cmd[g]),
            .up_data   (up_w),
            .down_data (down_w),
            .data_q    (cell_q[g])
        );
    end

    pse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cell_q[1]),
        .divisor  (cell_q[0]),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Depth never exceeds the stack size
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // Divider completes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV_WAIT)
        else $error("divider done outside wait state");

    // An error token leaves the depth unchanged
    a_err_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        apply && status_reg != STAT_OK |=> $stable(depth_reg))
        else $error("depth changed on error token");

    // A committed push grows the stack by one entry
    a_push_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        apply && act_reg == ACT_PUSH |=> depth_reg == $past(depth_reg) + DW'(1))
        else $error("push did not grow the stack");

    // An accepted beat is followed by its decode in EXEC
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> state_reg == S_EXEC)
        else $error("token not decoded after accept");

endmodule

// ===== rtl/core/pse_cell.sv =====
module pse_cell
    import pse_pkg::*;
(
    input  logic               aclk,
    input  cell_cmd_t          cmd,
    input  logic [VALUE_W-1:0] up_data,
    input  logic [VALUE_W-1:0] down_data,
    output logic [VALUE_W-1:0] data_q
);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;

    // Take from the neighbor above on push, from below on pop
    always_comb begin
        case (cmd)
            CELL_LOAD_UP:   data_next = up_data;
            CELL_LOAD_DOWN: data_next = down_data;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

// ===== rtl/core/pse_div.sv =====
module pse_div
    import pse_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [VALUE_W-1:0] divisor,
    output logic               done,
    output logic [VALUE_W-1:0] quotient
);

    div_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic [VALUE_W-1:0]   quo_reg, quo_next;
    logic [VALUE_W-1:0]   dmag_reg, dmag_next;
    logic                 neg_reg, neg_next;
    logic [VALUE_W:0]     rem_shift;
    logic [VALUE_W:0]     rem_diff;

    // One restoring step: shift in the next dividend bit, try to subtract
    assign rem_shift = {rem_reg, quo_reg[VALUE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dmag_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    quo_next   = dividend[VALUE_W-1] ? (VALUE_W'(0) - dividend) : dividend;
                    dmag_next  = divisor[VALUE_W-1] ? (VALUE_W'(0) - divisor) : divisor;
                    neg_next   = dividend[VALUE_W-1] ^ divisor[VALUE_W-1];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (!rem_diff[VALUE_W]) begin
                    rem_next = rem_diff[VALUE_W-1:0];
                    quo_next = {quo_reg[VALUE_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[VALUE_W-1:0];
                    quo_next = {quo_reg[VALUE_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = DIV_FIX;
                end
            end
            DIV_FIX: begin
                state_next = DIV_IDLE;
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    // Restore the sign of the truncated quotient
    assign done     = (state_reg == DIV_FIX);
    assign quotient = neg_reg ? (VALUE_W'(0) - quo_reg) : quo_reg;

endmodule
